### src/wdb_pkg.sv
// shared types and constants of the watchdog bank
package wdb_pkg;

    localparam int NUM_DOGS  = 4;
    localparam int IDX_W     = 2;
    localparam int ACT_W     = 3;
    localparam int LIM_W     = 16;
    localparam int CNT_W     = LIM_W + 1;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam logic [LIM_W-1:0] DEFAULT_LIMIT = LIM_W'(20);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACTIVE_DOGS   = 3'd0,
        REG_LIMIT_DOG0    = 3'd1,
        REG_LIMIT_DOG1    = 3'd2,
        REG_LIMIT_DOG2    = 3'd3,
        REG_LIMIT_DOG3    = 3'd4,
        REG_LED_ENABLE    = 3'd5,
        REG_TIMEOUT_NOTE  = 3'd6,
        REG_FEED_CHECK    = 3'd7
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_OFFLINE = 2'd0,
        ST_ONLINE  = 2'd1,
        ST_ERROR   = 2'd2
    } t_status;

    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_FEED = 1'b1;

    typedef struct packed {
        logic             tick;
        logic             feed;
        logic             check;
        logic             healthy;
        logic             led_en;
        logic [LIM_W-1:0] limit;
    } t_chan_ctl;

    typedef struct packed {
        logic    expired;
        logic    led;
        t_status status;
    } t_chan_sts;

endpackage

### src/wdb_if.sv
// handshake channels of the watchdog bank
interface wdb_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [1:0] dog_index;
    logic       feed_healthy;

    modport source (output valid, action, dog_index, feed_healthy, input ready);
    modport sink   (input valid, action, dog_index, feed_healthy, output ready);
endinterface

interface wdb_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] expired_mask;
    logic [3:0] notify_mask;
    logic [3:0] led_levels;
    logic [1:0] fed_state;

    modport source (output valid, expired_mask, notify_mask, led_levels, fed_state,
                    input ready);
    modport sink   (input valid, expired_mask, notify_mask, led_levels, fed_state,
                    output ready);
endinterface

interface wdb_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### src/wdb_chan.sv
// one watchdog channel: life counter, status and indicator level
module wdb_chan
    import wdb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_chan_ctl i_ctl,
    output t_chan_sts o_sts
);

    logic [CNT_W-1:0] r_count;
    t_status          r_status;
    logic             r_led;

    logic [CNT_W-1:0] n_count;
    t_status          n_status;
    logic             n_led;

    logic [CNT_W-1:0] eff_lim;
    logic [CNT_W-1:0] lim_p1;
    logic [CNT_W-1:0] inc;
    logic [CNT_W-1:0] sat;
    logic             over;

    always_comb begin
        eff_lim = (i_ctl.limit == '0) ? CNT_W'(DEFAULT_LIMIT) : CNT_W'(i_ctl.limit);
        lim_p1  = eff_lim + CNT_W'(1);
        inc     = r_count + CNT_W'(1);
        sat     = (inc > lim_p1) ? lim_p1 : inc;
        over    = sat > eff_lim;

        n_count  = r_count;
        n_status = r_status;
        n_led    = r_led;
        if (i_ctl.tick) begin
            n_count = sat;
            if (over) begin
                n_status = ST_OFFLINE;
                if (i_ctl.led_en) begin
                    n_led = 1'b0;
                end
            end
        end else if (i_ctl.feed) begin
            n_count  = '0;
            n_status = (i_ctl.check && !i_ctl.healthy) ? ST_ERROR : ST_ONLINE;
            if (i_ctl.led_en) begin
                n_led = 1'b1;
            end
        end

        o_sts.expired = i_ctl.tick && over;
        o_sts.led     = n_led;
        o_sts.status  = n_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_status <= ST_OFFLINE;
            r_led    <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_status <= n_status;
            r_led    <= n_led;
        end
    end

endmodule

### src/multi_channel_watchdog_bank_top.sv
// top level of the multi-channel watchdog bank
// Each tick or feed transfer is registered into the result register and gives exactly
// one result transfer; a new item is taken every cycle while the result register is
// free or being read. The per-channel compare and saturating increment of all four
// channels run in parallel. Configuration writes are taken at any time and are meant
// to be made while the bank is idle.
module multi_channel_watchdog_bank_top
    import wdb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    wdb_in_if.sink     i_in,
    wdb_out_if.source  o_out,
    wdb_cfg_if.sink    i_cfg
);

    logic [ACT_W-1:0]    r_active;
    logic [LIM_W-1:0]    r_limit [NUM_DOGS];
    logic [NUM_DOGS-1:0] r_led_en;
    logic [NUM_DOGS-1:0] r_notify_en;
    logic [NUM_DOGS-1:0] r_check_en;

    logic                r_out_valid;
    logic [NUM_DOGS-1:0] r_expired;
    logic [NUM_DOGS-1:0] r_notify;
    logic [NUM_DOGS-1:0] r_leds;
    logic [1:0]          r_fed;

    logic                take;
    logic                cfg_take;
    logic [NUM_DOGS-1:0] active_vec;
    logic [NUM_DOGS-1:0] n_expired;
    logic [NUM_DOGS-1:0] n_leds;
    logic [1:0]          n_fed;
    t_chan_ctl           ctl [NUM_DOGS];
    t_chan_sts           sts [NUM_DOGS];

    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign take        = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;
    assign cfg_take    = i_cfg.valid;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= '0;
            r_led_en    <= '0;
            r_notify_en <= '0;
            r_check_en  <= '0;
            for (int c = 0; c < NUM_DOGS; c++) begin
                r_limit[c] <= DEFAULT_LIMIT;
            end
        end else if (cfg_take) begin
            unique case (t_cfg_reg'(i_cfg.index))
                REG_ACTIVE_DOGS:  r_active    <= i_cfg.data[ACT_W-1:0];
                REG_LIMIT_DOG0:   r_limit[0]  <= i_cfg.data[LIM_W-1:0];
                REG_LIMIT_DOG1:   r_limit[1]  <= i_cfg.data[LIM_W-1:0];
                REG_LIMIT_DOG2:   r_limit[2]  <= i_cfg.data[LIM_W-1:0];
                REG_LIMIT_DOG3:   r_limit[3]  <= i_cfg.data[LIM_W-1:0];
                REG_LED_ENABLE:   r_led_en    <= i_cfg.data[NUM_DOGS-1:0];
                REG_TIMEOUT_NOTE: r_notify_en <= i_cfg.data[NUM_DOGS-1:0];
                REG_FEED_CHECK:   r_check_en  <= i_cfg.data[NUM_DOGS-1:0];
                default: ;
            endcase
        end
    end

    // per channel control and the channels themselves
    for (genvar c = 0; c < NUM_DOGS; c++) begin : g_chan
        assign active_vec[c] = r_active > ACT_W'(c);

        always_comb begin
            ctl[c].tick    = take && (i_in.action == ACT_TICK) && active_vec[c];
            ctl[c].feed    = take && (i_in.action == ACT_FEED) && active_vec[c]
                             && (i_in.dog_index == IDX_W'(c));
            ctl[c].check   = r_check_en[c];
            ctl[c].healthy = i_in.feed_healthy;
            ctl[c].led_en  = r_led_en[c];
            ctl[c].limit   = r_limit[c];
        end

        wdb_chan u_chan (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl[c]),
            .o_sts   (sts[c])
        );

        assign n_expired[c] = sts[c].expired;
        assign n_leds[c]    = sts[c].led;
    end

    always_comb begin
        n_fed = ST_OFFLINE;
        if (i_in.action == ACT_FEED && active_vec[i_in.dog_index]) begin
            n_fed = sts[i_in.dog_index].status;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_expired <= n_expired;
            r_notify  <= n_expired & r_notify_en;
            r_leds    <= n_leds & r_led_en;
            r_fed     <= n_fed;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.expired_mask = r_expired;
    assign o_out.notify_mask  = r_notify;
    assign o_out.led_levels   = r_leds;
    assign o_out.fed_state    = r_fed;

endmodule
